/* rtl/exponential_pitch_sine_oscillator_macros.svh */
// Assertion macros used by the checker file.
`ifndef EXPONENTIAL_PITCH_SINE_OSCILLATOR_MACROS_SVH
`define EXPONENTIAL_PITCH_SINE_OSCILLATOR_MACROS_SVH

// Same-cycle implication.
`define EPSO_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EPSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/epso_pkg.sv */
package epso_pkg;

	localparam int PHASE_BITS_DEF  = 32;
	localparam int SINE_DEPTH_DEF  = 1024;
	localparam int EXP_DEPTH_DEF   = 256;

	localparam int PITCH_W     = 17;
	localparam int OFFSET_W    = 15;
	localparam int INC_W       = 32;
	localparam int WAVE_W      = 16;
	localparam int MAG_W       = 15;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int FRAC_W      = 12;
	localparam int OCT_W       = 4;
	localparam int SUM_W       = 18;
	localparam int UPITCH_W    = 16;

	localparam logic signed [SUM_W-1:0] PITCH_LIMIT = 18'sd16384;

	localparam logic signed [OFFSET_W-1:0] OFFSET_RST    = '0;
	localparam logic [INC_W-1:0]           BASE_INC_RST  = 32'd23409;
	localparam logic [INC_W-1:0]           BLINK_INC_RST = 32'd89478;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PITCH_OFFSET,
		REG_BASE_INC,
		REG_BLINK_INC
	} reg_index_t;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam logic [63:0] Q30_LN2     = 64'd744261118;

	// 2^(k / 2^lg) in Q30, Taylor series in Horner form
	function automatic logic [63:0] exp_rom(input logic [63:0] k, input int lg);
		logic [63:0] y;
		logic [63:0] t;
		y = (k * Q30_LN2) >> lg;
		t = Q30_ONE;
		t = Q30_ONE + ((y * t) >> 30) / 12;
		t = Q30_ONE + ((y * t) >> 30) / 11;
		t = Q30_ONE + ((y * t) >> 30) / 10;
		t = Q30_ONE + ((y * t) >> 30) / 9;
		t = Q30_ONE + ((y * t) >> 30) / 8;
		t = Q30_ONE + ((y * t) >> 30) / 7;
		t = Q30_ONE + ((y * t) >> 30) / 6;
		t = Q30_ONE + ((y * t) >> 30) / 5;
		t = Q30_ONE + ((y * t) >> 30) / 4;
		t = Q30_ONE + ((y * t) >> 30) / 3;
		t = Q30_ONE + ((y * t) >> 30) / 2;
		t = Q30_ONE + ((y * t) >> 30);
		return t;
	endfunction

	// 32767 * sin(r / 2^lg * pi/2), rounded and clamped
	function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] r, input int lg);
		logic [63:0] th;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		th = (r * Q30_HALF_PI) >> lg;
		x2 = (th * th) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 156;
		t = Q30_ONE - ((x2 * t) >> 30) / 110;
		t = Q30_ONE - ((x2 * t) >> 30) / 72;
		t = Q30_ONE - ((x2 * t) >> 30) / 42;
		t = Q30_ONE - ((x2 * t) >> 30) / 20;
		t = Q30_ONE - ((x2 * t) >> 30) / 6;
		s = (th * t) >> 30;
		v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return MAG_W'(v);
	endfunction

endpackage

/* rtl/epso_in_if.sv */
interface epso_in_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [epso_pkg::PITCH_W-1:0]       pitch_cv;

	modport source (output valid, output pitch_cv, input ready);
	modport sink   (input valid, input pitch_cv, output ready);
endinterface

/* rtl/epso_out_if.sv */
interface epso_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [epso_pkg::WAVE_W-1:0]  wave_out;
	logic                                blink_on;

	modport source (output valid, output wave_out, output blink_on, input ready);
	modport sink   (input valid, input wave_out, input blink_on, output ready);
endinterface

/* rtl/epso_cfg_if.sv */
interface epso_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [epso_pkg::CFG_INDEX_W-1:0]      index;
	logic [epso_pkg::CFG_DATA_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/exponential_pitch_sine_oscillator.sv */
// channel   dir  payload                      transfer
// pitch     in   pitch_cv[16:0] signed        valid & ready
// wave      out  wave_out[15:0] signed, blink  valid & ready
// cfg       in   index[1:0], data[31:0]       valid & ready (ready tied high)
//
// One pitch sample per cycle while the output is not stalled.
// Stages: clamp + exp2 lookup, interpolation multiply, base multiply,
// shift + phase add, sine lookup, output register.
// Async reset clears valids, phases and config to defaults.
// A stalled output freezes the whole pipe; pitch.ready drops with it.
module exponential_pitch_sine_oscillator #(
	parameter int PHASE_BITS       = epso_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = epso_pkg::SINE_DEPTH_DEF,
	parameter int EXP_TABLE_DEPTH  = epso_pkg::EXP_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	epso_in_if.sink     pitch,
	epso_out_if.source  wave,
	epso_cfg_if.sink    cfg
);

	localparam int EXP_LG  = $clog2(EXP_TABLE_DEPTH);
	localparam int SINE_LG = $clog2(SINE_TABLE_DEPTH);
	localparam int QN      = SINE_TABLE_DEPTH / 4;
	localparam int QIW     = SINE_LG - 1;
	localparam logic [QIW-1:0] QN_C = QIW'(QN);

	// constant tables
	logic [31:0]                     exp_tab [EXP_TABLE_DEPTH+1];
	logic [epso_pkg::MAG_W-1:0]      qsin_tab [QN+1];

	for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_exp
		assign exp_tab[gi] = 32'(epso_pkg::exp_rom(64'(gi), EXP_LG));
	end

	for (genvar gj = 0; gj <= QN; gj++) begin : g_sin
		assign qsin_tab[gj] = epso_pkg::quarter_sine(64'(4 * gj), SINE_LG);
	end

	// config
	logic signed [epso_pkg::OFFSET_W-1:0] offset_q;
	logic [epso_pkg::INC_W-1:0]           base_inc_q;
	logic [epso_pkg::INC_W-1:0]           blink_inc_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= epso_pkg::OFFSET_RST;
			base_inc_q  <= epso_pkg::BASE_INC_RST;
			blink_inc_q <= epso_pkg::BLINK_INC_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				epso_pkg::REG_PITCH_OFFSET: offset_q    <= cfg.data[epso_pkg::OFFSET_W-1:0];
				epso_pkg::REG_BASE_INC:     base_inc_q  <= cfg.data;
				epso_pkg::REG_BLINK_INC:    blink_inc_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic en;

	assign en          = !out_valid_q || wave.ready;
	assign pitch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pitch.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// stage 1: input register
	logic signed [epso_pkg::PITCH_W-1:0] pitch_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_s1 <= pitch.pitch_cv;
		end
	end

	// clamp, split into octave and fraction, exp2 lookup
	logic signed [epso_pkg::SUM_W-1:0] sum;
	logic signed [epso_pkg::SUM_W-1:0] clamped;
	logic [epso_pkg::UPITCH_W-1:0]     upitch;
	logic [epso_pkg::FRAC_W-1:0]       frac;
	logic [EXP_LG-1:0]                 idx;
	logic [EXP_LG:0]                   idx0, idx1;
	logic [epso_pkg::FRAC_W-1:0]       rem;
	logic [31:0]                       e0, e1;

	always_comb begin
		sum = epso_pkg::SUM_W'(pitch_s1) + epso_pkg::SUM_W'(offset_q);
		if (sum > epso_pkg::PITCH_LIMIT) begin
			clamped = epso_pkg::PITCH_LIMIT;
		end else if (sum < -epso_pkg::PITCH_LIMIT) begin
			clamped = -epso_pkg::PITCH_LIMIT;
		end else begin
			clamped = sum;
		end
		upitch = epso_pkg::UPITCH_W'(clamped + epso_pkg::PITCH_LIMIT);
		frac   = upitch[epso_pkg::FRAC_W-1:0];
		idx    = frac[epso_pkg::FRAC_W-1 -: EXP_LG];
		rem    = frac << EXP_LG;
		idx0   = {1'b0, idx};
		idx1   = idx0 + 1'b1;
		e0     = exp_tab[idx0];
		e1     = exp_tab[idx1];
	end

	// stage 2
	logic [31:0]                 e0_s2, diff_s2;
	logic [epso_pkg::FRAC_W-1:0] rem_s2;
	logic [epso_pkg::OCT_W-1:0]  oct_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s2   <= e0;
			diff_s2 <= e1 - e0;
			rem_s2  <= rem;
			oct_s2  <= upitch[epso_pkg::UPITCH_W-1:epso_pkg::FRAC_W];
		end
	end

	// linear interpolation
	logic [43:0] interp;

	assign interp = 44'(diff_s2) * 44'(rem_s2);

	// stage 3
	logic [31:0]                m_s3;
	logic [epso_pkg::OCT_W-1:0] oct_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3   <= e0_s2 + 32'(interp >> epso_pkg::FRAC_W);
			oct_s3 <= oct_s2;
		end
	end

	// stage 4: base increment times mantissa
	logic [63:0]                prod_s4;
	logic [epso_pkg::OCT_W-1:0] oct_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= 64'(base_inc_q) * 64'(m_s3);
			oct_s4  <= oct_s3;
		end
	end

	// octave shift and phase accumulators
	logic [5:0]            shamt;
	logic [PHASE_BITS-1:0] inc;
	logic [PHASE_BITS-1:0] osc_phase_q, blink_phase_q;
	logic [PHASE_BITS-1:0] osc_next, blink_next;

	always_comb begin
		shamt      = 6'd34 - {2'b00, oct_s4};
		inc        = PHASE_BITS'(prod_s4 >> shamt);
		osc_next   = osc_phase_q + inc;
		blink_next = blink_phase_q + PHASE_BITS'(blink_inc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_phase_q   <= '0;
			blink_phase_q <= '0;
		end else if (en && v_s4) begin
			osc_phase_q   <= osc_next;
			blink_phase_q <= blink_next;
		end
	end

	// stage 5
	logic [SINE_LG-1:0] k_s5;
	logic               blink_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			k_s5     <= osc_next[PHASE_BITS-1 -: SINE_LG];
			blink_s5 <= !blink_next[PHASE_BITS-1];
		end
	end

	// quarter-wave sine lookup
	logic [QIW-1:0]                       qidx;
	logic [epso_pkg::MAG_W-1:0]           mag;
	logic signed [epso_pkg::WAVE_W-1:0]   mag_ext;
	logic signed [epso_pkg::WAVE_W-1:0]   sine;

	always_comb begin
		qidx = {1'b0, k_s5[SINE_LG-3:0]};
		if (k_s5[SINE_LG-2]) begin
			qidx = QN_C - qidx;
		end
		mag     = qsin_tab[qidx];
		mag_ext = epso_pkg::WAVE_W'(mag);
		sine    = k_s5[SINE_LG-1] ? -mag_ext : mag_ext;
	end

	// output register
	logic signed [epso_pkg::WAVE_W-1:0] wave_q;
	logic                               blink_q;

	always_ff @(posedge clk) begin
		if (en) begin
			wave_q  <= sine;
			blink_q <= blink_s5;
		end
	end

	assign wave.valid    = out_valid_q;
	assign wave.wave_out = wave_q;
	assign wave.blink_on = blink_q;

endmodule

/* rtl/epso_checker.sv */
`include "exponential_pitch_sine_oscillator_macros.svh"

module epso_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [epso_pkg::WAVE_W-1:0]  wave_out,
	input logic                                blink_on
);

	localparam logic [2:0] MAX_PENDING = 3'd6;

	logic [2:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b00, in_xfer} - {2'b00, out_xfer};
		end
	end

	`EPSO_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(wave_out) && $stable(blink_on), "result changed while stalled")
	`EPSO_ASSERT_HOLDS(a_no_spurious, clk, arst_n, out_xfer, pending_q != 3'd0, "result without a pending pitch sample")
	`EPSO_ASSERT_HOLDS(a_depth, clk, arst_n, 1'b1, pending_q <= MAX_PENDING, "more samples in flight than pipeline stages")
	`EPSO_ASSERT_HOLDS(a_flow, clk, arst_n, !out_valid || out_ready, in_ready, "input stalled while output is free")

endmodule

bind exponential_pitch_sine_oscillator epso_checker u_epso_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pitch.valid),
	.in_ready  (pitch.ready),
	.out_valid (wave.valid),
	.out_ready (wave.ready),
	.wave_out  (wave.wave_out),
	.blink_on  (wave.blink_on)
);
